@@ rtl/htfc_pkg.sv @@
// Package: constants and CRC-8 step function for the humidity/temperature frame checker.
`timescale 1ns / 1ps
`default_nettype none
package htfc_pkg;

   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [14:0] TEMP_SCALE  = 15'd21875;
   localparam logic [13:0] HUM_SCALE   = 14'd12500;
   localparam int          CONV_SHIFT  = 13;
   localparam logic [17:0] TEMP_OFFSET = 18'd45000;

   localparam logic [2:0] POS_FIRST    = 3'd0;
   localparam logic [2:0] POS_TEMP_CRC = 3'd2;
   localparam logic [2:0] POS_MID      = 3'd3;
   localparam logic [2:0] POS_END      = 3'd6;
   localparam logic [2:0] LEN_MEAS     = 3'd6;
   localparam logic [2:0] LEN_STATUS   = 3'd3;

   localparam logic KIND_MEAS   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // MSB-first CRC-8 over one byte, no final xor
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ rtl/humidity_temp_frame_checker_top.sv @@
// Top level: sensor frame byte tracking, CRC check and result register.
// A result becomes valid once the last accepted byte of a frame has passed the
// input register and then the result register.
// Throughput: one byte per cycle; the input register advances whenever the
// result register is empty or being drained.
// Reset: synchronous, active high; clears byte position, frame type, held words
// and flags, and sets the running CRC to 0xFF.
`timescale 1ns / 1ps
`default_nettype none
module humidity_temp_frame_checker_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_kind,
   input  wire logic               req_frame_start,
   input  wire logic [7:0]         req_data_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_result_kind,
   output logic signed [17:0]      rsp_temperature_milli_c,
   output logic [16:0]             rsp_humidity_milli_pct,
   output logic [15:0]             rsp_temp_raw,
   output logic [15:0]             rsp_hum_raw,
   output logic                    rsp_temp_crc_ok,
   output logic                    rsp_hum_crc_ok,
   output logic [15:0]             rsp_status_word,
   output logic                    rsp_online
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic       in_kind_ff, in_start_ff;
   logic [7:0] in_byte_ff;

   // frame state
   logic [2:0]  pos_ff, pos_in;
   logic        type_ff, type_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  hi_ff, hi_in;
   logic [7:0]  lo_ff, lo_in;
   logic [15:0] temp_ff, temp_in;
   logic [15:0] hum_ff, hum_in;
   logic [15:0] status_ff, status_in;
   logic        temp_ok_ff, temp_ok_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic               out_kind_ff, out_kind_in;
   logic signed [17:0] out_temp_c_ff, out_temp_c_in;
   logic [16:0]        out_hum_p_ff, out_hum_p_in;
   logic [15:0]        out_temp_raw_ff, out_temp_raw_in;
   logic [15:0]        out_hum_raw_ff, out_hum_raw_in;
   logic               out_temp_ok_ff, out_temp_ok_in;
   logic               out_hum_ok_ff, out_hum_ok_in;
   logic [15:0]        out_status_ff, out_status_in;
   logic               out_online_ff, out_online_in;

   logic        go;
   logic [2:0]  eff_pos;
   logic        eff_type;
   logic [2:0]  frame_len;
   logic        active;
   logic        crc_ok;
   logic [15:0] word;
   logic [15:0] hum_next;
   logic signed [17:0] conv_temp;
   logic [16:0] conv_hum;

   assign go        = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || go;

   assign eff_pos   = in_start_ff ? htfc_pkg::POS_FIRST : pos_ff;
   assign eff_type  = in_start_ff ? in_kind_ff : type_ff;
   assign frame_len = eff_type ? htfc_pkg::LEN_STATUS : htfc_pkg::LEN_MEAS;
   assign active    = eff_pos < frame_len;
   assign crc_ok    = crc_ff == in_byte_ff;
   assign word      = {hi_ff, lo_ff};
   assign hum_next  = crc_ok ? word : hum_ff;

   htfc_convert u_convert (
      .temp_raw            (temp_ff),
      .hum_raw             (hum_next),
      .temperature_milli_c (conv_temp),
      .humidity_milli_pct  (conv_hum)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end

      pos_in     = pos_ff;
      type_in    = type_ff;
      crc_in     = crc_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      temp_in    = temp_ff;
      hum_in     = hum_ff;
      status_in  = status_ff;
      temp_ok_in = temp_ok_ff;

      out_valid_in    = out_valid_ff && !rsp_ready;
      out_kind_in     = out_kind_ff;
      out_temp_c_in   = out_temp_c_ff;
      out_hum_p_in    = out_hum_p_ff;
      out_temp_raw_in = out_temp_raw_ff;
      out_hum_raw_in  = out_hum_raw_ff;
      out_temp_ok_in  = out_temp_ok_ff;
      out_hum_ok_in   = out_hum_ok_ff;
      out_status_in   = out_status_ff;
      out_online_in   = out_online_ff;

      if (go) begin
         type_in = eff_type;
         pos_in  = eff_pos;
         if (in_start_ff) begin
            crc_in = htfc_pkg::CRC_INIT;
         end
         if (active) begin
            pos_in = eff_pos + 3'd1;
            case (eff_pos)
               3'd0, 3'd3: begin
                  hi_in  = in_byte_ff;
                  crc_in = htfc_pkg::crc8_byte(htfc_pkg::CRC_INIT, in_byte_ff);
               end
               3'd1, 3'd4: begin
                  lo_in  = in_byte_ff;
                  crc_in = htfc_pkg::crc8_byte(crc_ff, in_byte_ff);
               end
               default: begin
                  crc_in = htfc_pkg::CRC_INIT;
                  if (eff_type == htfc_pkg::KIND_STATUS) begin
                     if (crc_ok) begin
                        status_in = word;
                     end
                     out_valid_in    = 1'b1;
                     out_kind_in     = htfc_pkg::KIND_STATUS;
                     out_temp_c_in   = '0;
                     out_hum_p_in    = '0;
                     out_temp_raw_in = '0;
                     out_hum_raw_in  = '0;
                     out_temp_ok_in  = 1'b0;
                     out_hum_ok_in   = 1'b0;
                     out_status_in   = crc_ok ? word : status_ff;
                     out_online_in   = crc_ok;
                  end else if (eff_pos == htfc_pkg::POS_TEMP_CRC) begin
                     if (crc_ok) begin
                        temp_in = word;
                     end
                     temp_ok_in = crc_ok;
                  end else begin
                     hum_in          = hum_next;
                     out_valid_in    = 1'b1;
                     out_kind_in     = htfc_pkg::KIND_MEAS;
                     out_temp_c_in   = conv_temp;
                     out_hum_p_in    = conv_hum;
                     out_temp_raw_in = temp_ff;
                     out_hum_raw_in  = hum_next;
                     out_temp_ok_in  = temp_ok_ff;
                     out_hum_ok_in   = crc_ok;
                     out_status_in   = '0;
                     out_online_in   = 1'b0;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= htfc_pkg::POS_FIRST;
         type_ff      <= htfc_pkg::KIND_MEAS;
         crc_ff       <= htfc_pkg::CRC_INIT;
         hi_ff        <= '0;
         lo_ff        <= '0;
         temp_ff      <= '0;
         hum_ff       <= '0;
         status_ff    <= '0;
         temp_ok_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
         type_ff      <= type_in;
         crc_ff       <= crc_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
         temp_ff      <= temp_in;
         hum_ff       <= hum_in;
         status_ff    <= status_in;
         temp_ok_ff   <= temp_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff  <= req_kind;
         in_start_ff <= req_frame_start;
         in_byte_ff  <= req_data_byte;
      end
      out_kind_ff     <= out_kind_in;
      out_temp_c_ff   <= out_temp_c_in;
      out_hum_p_ff    <= out_hum_p_in;
      out_temp_raw_ff <= out_temp_raw_in;
      out_hum_raw_ff  <= out_hum_raw_in;
      out_temp_ok_ff  <= out_temp_ok_in;
      out_hum_ok_ff   <= out_hum_ok_in;
      out_status_ff   <= out_status_in;
      out_online_ff   <= out_online_in;
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_result_kind         = out_kind_ff;
   assign rsp_temperature_milli_c = out_temp_c_ff;
   assign rsp_humidity_milli_pct  = out_hum_p_ff;
   assign rsp_temp_raw            = out_temp_raw_ff;
   assign rsp_hum_raw             = out_hum_raw_ff;
   assign rsp_temp_crc_ok         = out_temp_ok_ff;
   assign rsp_hum_crc_ok          = out_hum_ok_ff;
   assign rsp_status_word         = out_status_ff;
   assign rsp_online              = out_online_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= htfc_pkg::POS_END)
      else $error("byte position out of range");

   a_status_pos: assert property (@(posedge clock) disable iff (reset)
      type_ff == htfc_pkg::KIND_STATUS |-> pos_ff <= htfc_pkg::LEN_STATUS)
      else $error("status frame position past its length");

   a_crc_boundary: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == htfc_pkg::POS_FIRST || pos_ff == htfc_pkg::POS_MID ||
       pos_ff == htfc_pkg::POS_END) |-> crc_ff == htfc_pkg::CRC_INIT)
      else $error("running CRC not reseeded at word boundary");

   a_meas_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == htfc_pkg::KIND_MEAS |->
         out_status_ff == '0 && !out_online_ff)
      else $error("measurement item carries status fields");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == htfc_pkg::KIND_STATUS |->
         out_temp_raw_ff == '0 && out_hum_raw_ff == '0 && !out_temp_ok_ff)
      else $error("status item carries measurement fields");

endmodule
`default_nettype wire

@@ rtl/htfc_convert.sv @@
// Raw sensor word to milli-degree and milli-percent conversion.
`timescale 1ns / 1ps
`default_nettype none
module htfc_convert (
   input  wire logic [15:0]        temp_raw,
   input  wire logic [15:0]        hum_raw,
   output logic signed [17:0]      temperature_milli_c,
   output logic [16:0]             humidity_milli_pct
);

   logic [30:0] temp_prod;
   logic [29:0] hum_prod;
   logic [17:0] temp_scaled;

   assign temp_prod   = 31'(htfc_pkg::TEMP_SCALE) * 31'(temp_raw);
   assign hum_prod    = 30'(htfc_pkg::HUM_SCALE) * 30'(hum_raw);
   assign temp_scaled = temp_prod[30:htfc_pkg::CONV_SHIFT];

   assign temperature_milli_c = $signed(temp_scaled - htfc_pkg::TEMP_OFFSET);
   assign humidity_milli_pct  = hum_prod[29:htfc_pkg::CONV_SHIFT];

endmodule
`default_nettype wire
